[design/pcef_pkg.sv]
// Shared constants and types for the period counter with EMA frequency unit
`timescale 1ns / 1ps

package pcef_pkg;

  localparam int CHANNELS_DEF  = 2;
  localparam int FRAC_BITS_DEF = 8;

  localparam int TS_W    = 32;
  localparam int ALPHA_W = 8;
  localparam int FREQ_W  = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd77;
  localparam logic [FREQ_W-1:0]  FREQ_SCALE  = 24'd10000000;
  localparam logic [FREQ_W-1:0]  FREQ_LIMIT  = 24'd10000000;

  typedef enum logic [0:0] {
    OP_EDGE   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

[design/period_counter_with_ema_frequency_unit.sv]
// Edge request, or a sample with no period to load: result loaded from S_OUT after acceptance.
// Sample request: the request passes S_EMA, S_DIV and S_OUT before its result is loaded,
//   which hold the 8-step serial alpha multiply and the one-bit-per-cycle reciprocal divider;
//   a first load skips the multiply and goes straight to S_DIV.
// A next request can be taken in the cycle after the load; an untaken output result holds the load back.
// Synchronous active-high reset: channel state zeroed, awaiting-first set, alpha = 77.
`timescale 1ns / 1ps

module period_counter_with_ema_frequency_unit #(
  parameter int CHANNELS  = pcef_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = pcef_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pcef_pkg::ALPHA_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic                                 channel,
  input  logic [pcef_pkg::TS_W-1:0]            timestamp_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 result_channel,
  output logic [pcef_pkg::TS_W-1:0]            period_us,
  output logic [pcef_pkg::TS_W-1:0]            pulse_count,
  output logic                                 indicator_level,
  output logic [pcef_pkg::TS_W+FRAC_BITS-1:0]  smoothed_period_q8,
  output logic [pcef_pkg::FREQ_W-1:0]          frequency_tenths_hz
);

  localparam int AW   = pcef_pkg::TS_W + FRAC_BITS;
  localparam int TW   = pcef_pkg::TS_W;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0] CH_N = (CH_W + 1)'(CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EMA  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [pcef_pkg::ALPHA_W-1:0] alpha;
  logic                         cur_ch;
  logic                         bad;

  logic [TW-1:0]              last_capture  [CHANNELS];
  logic [TW-1:0]              latest_period [CHANNELS];
  logic [TW-1:0]              edge_count    [CHANNELS];
  logic                       indicator     [CHANNELS];
  logic [AW-1:0]              average       [CHANNELS];
  logic                       awaiting      [CHANNELS];
  logic [pcef_pkg::FREQ_W-1:0] freq_c       [CHANNELS];

  logic [CH_W-1:0] in_idx, cur_idx, rd_idx;
  logic            ch_ok;
  logic            in_acc;
  logic            is_edge;
  logic [TW-1:0]   per;
  logic [AW-1:0]   target;
  logic            first_load;
  logic            ema_start;
  logic            ema_done;
  logic [AW-1:0]   ema_res;
  logic            div_start;
  logic            div_done;
  logic [AW-1:0]   div_d;
  logic [pcef_pkg::FREQ_W-1:0] div_freq;
  logic            out_take;
  logic            load;

  assign in_idx   = CH_W'(channel);
  assign cur_idx  = CH_W'(cur_ch);
  assign rd_idx   = (state == S_IDLE) ? in_idx : cur_idx;
  assign ch_ok    = {1'b0, in_idx} < CH_N;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_edge  = (opcode == pcef_pkg::OP_EDGE);

  assign per    = latest_period[rd_idx];
  assign target = {per, FRAC_BITS'(0)};

  assign first_load = in_acc && ch_ok && !is_edge && (per != '0) && awaiting[rd_idx];
  assign ema_start  = in_acc && ch_ok && !is_edge && (per != '0) && !awaiting[rd_idx];
  assign div_start  = first_load || ema_done;
  assign div_d      = ema_done ? ema_res : target;

  assign out_take = out_valid && !out_stall;
  assign load     = (state == S_OUT) && !(out_valid && out_stall);

  pcef_ema #(.AW(AW)) u_ema (
    .clk    (clk),
    .rst    (rst),
    .start  (ema_start),
    .avg    (average[rd_idx]),
    .target (target),
    .alpha  (alpha),
    .done   (ema_done),
    .result (ema_res)
  );

  pcef_div #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (div_d),
    .done    (div_done),
    .freq    (div_freq)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (ema_start) begin
            state_next = S_EMA;
          end else if (first_load) begin
            state_next = S_DIV;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_EMA: begin
        if (ema_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      alpha  <= pcef_pkg::ALPHA_RESET;
      cur_ch <= 1'b0;
      bad    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        alpha <= cfg_data;
      end
      if (in_acc) begin
        cur_ch <= channel;
        bad    <= !ch_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_capture[i]  <= '0;
        latest_period[i] <= '0;
        edge_count[i]    <= '0;
        indicator[i]     <= 1'b0;
        average[i]       <= '0;
        awaiting[i]      <= 1'b1;
        freq_c[i]        <= '0;
      end
    end else begin
      if (in_acc && ch_ok && is_edge) begin
        latest_period[in_idx] <= timestamp_us - last_capture[rd_idx];
        last_capture[in_idx]  <= timestamp_us;
        edge_count[in_idx]    <= edge_count[rd_idx] + 1'b1;
        indicator[in_idx]     <= !indicator[rd_idx];
      end
      if (first_load) begin
        average[in_idx]  <= target;
        awaiting[in_idx] <= 1'b0;
      end
      if (ema_done) begin
        average[cur_idx] <= ema_res;
      end
      if (div_done) begin
        freq_c[cur_idx] <= div_freq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_channel <= cur_ch;
      if (bad) begin
        period_us           <= '0;
        pulse_count         <= '0;
        indicator_level     <= 1'b0;
        smoothed_period_q8  <= '0;
        frequency_tenths_hz <= '0;
      end else begin
        period_us           <= latest_period[rd_idx];
        pulse_count         <= edge_count[rd_idx];
        indicator_level     <= indicator[rd_idx];
        smoothed_period_q8  <= average[rd_idx];
        frequency_tenths_hz <= freq_c[rd_idx];
      end
    end
  end

`ifndef SYNTHESIS
  a_ema_done_state: assert property (@(posedge clk) disable iff (rst)
    ema_done |-> state == S_EMA)
    else $error("smoothing step finished outside its state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its state");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_take && state != S_OUT |=> !out_valid)
    else $error("result register refilled without a finished request");

  a_zero_avg_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && smoothed_period_q8 == '0 |-> frequency_tenths_hz == '0)
    else $error("frequency reported without an average");
`endif

endmodule

[design/pcef_ema.sv]
// Bit-serial exponential smoothing step: one alpha bit per cycle
`timescale 1ns / 1ps

module pcef_ema #(
  parameter int AW = pcef_pkg::TS_W + pcef_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [AW-1:0]                avg,
  input  logic [AW-1:0]                target,
  input  logic [pcef_pkg::ALPHA_W-1:0] alpha,
  output logic                         done,
  output logic [AW-1:0]                result
);

  localparam int SW = AW + pcef_pkg::ALPHA_W + 1;
  localparam int CW = $clog2(pcef_pkg::ALPHA_W);
  localparam logic [CW-1:0] LAST = CW'(pcef_pkg::ALPHA_W - 1);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [pcef_pkg::ALPHA_W-1:0] abits;
  logic signed [SW-1:0]         acc;
  logic signed [SW-1:0]         step;
  logic signed [AW:0]           diff;

  // 256*avg + alpha*(target - avg), then drop the eight fraction bits of alpha
  assign diff   = signed'({1'b0, target}) - signed'({1'b0, avg});
  assign result = acc[AW+pcef_pkg::ALPHA_W-1:pcef_pkg::ALPHA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {1'b0, avg, pcef_pkg::ALPHA_W'(0)};
      step  <= SW'(diff);
      abits <= alpha;
    end else if (busy) begin
      if (abits[0]) begin
        acc <= acc + step;
      end
      step  <= step <<< 1;
      abits <= abits >> 1;
    end
  end

endmodule

[design/pcef_div.sv]
// Radix-2 restoring divider for the reciprocal frequency, saturated output
`timescale 1ns / 1ps

module pcef_div #(
  parameter int FRAC_BITS = pcef_pkg::FRAC_BITS_DEF,
  parameter int AW        = pcef_pkg::TS_W + FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [AW-1:0]               divisor,
  output logic                        done,
  output logic [pcef_pkg::FREQ_W-1:0] freq
);

  localparam int NW = pcef_pkg::FREQ_W + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] LAST  = CW'(NW - 1);
  localparam logic [NW-1:0] NUMER = {pcef_pkg::FREQ_SCALE, FRAC_BITS'(0)};
  localparam logic [NW-1:0] LIMIT = {FRAC_BITS'(0), pcef_pkg::FREQ_LIMIT};

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] dvs;
  logic [AW-1:0] rem;
  logic [NW-1:0] nq;     // numerator bits shift out, quotient bits shift in
  logic [AW:0]   trial;
  logic          ge;

  assign trial = {rem, nq[NW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign freq  = (nq > LIMIT) ? pcef_pkg::FREQ_LIMIT : nq[pcef_pkg::FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      nq  <= NUMER;
    end else if (busy) begin
      rem <= ge ? AW'(trial - {1'b0, dvs}) : trial[AW-1:0];
      nq  <= {nq[NW-2:0], ge};
    end
  end

endmodule

[tb/pcef_freq_checker.sv]
// Checker for the period counter: watches both channels, predicts each result and compares it
`timescale 1ns / 1ps

module pcef_freq_checker
  import pcef_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ALPHA_W-1:0]          cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        opcode,
  input  logic                        channel,
  input  logic [TS_W-1:0]             timestamp_us,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        result_channel,
  input  logic [TS_W-1:0]             period_us,
  input  logic [TS_W-1:0]             pulse_count,
  input  logic                        indicator_level,
  input  logic [TS_W+FRAC_BITS-1:0]   smoothed_period_q8,
  input  logic [FREQ_W-1:0]           frequency_tenths_hz,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic                      ch;
    logic [TS_W-1:0]           period;
    logic [TS_W-1:0]           pulses;
    logic                      level;
    logic [TS_W+FRAC_BITS-1:0] avg;
    logic [FREQ_W-1:0]         freq;
  } reading_t;

  reading_t expected_readings[$];

  logic [ALPHA_W-1:0]        alpha;
  logic [TS_W-1:0]           capture_ts [CHANNELS_DEF];
  logic [TS_W-1:0]           last_period[CHANNELS_DEF];
  logic [TS_W-1:0]           edges      [CHANNELS_DEF];
  logic                      level      [CHANNELS_DEF];
  logic [TS_W+FRAC_BITS-1:0] avg_period [CHANNELS_DEF];
  logic                      unloaded   [CHANNELS_DEF];

  function automatic reading_t advance_channel(op_t op, logic ch, logic [TS_W-1:0] ts);
    reading_t   r;
    logic [63:0] target;
    logic [63:0] mixed;
    logic [63:0] quot;
    if (op == OP_EDGE) begin
      last_period[ch] = ts - capture_ts[ch];
      capture_ts[ch] = ts;
      edges[ch] = edges[ch] + 1;
      level[ch] = ~level[ch];
    end else if (last_period[ch] != '0) begin
      target = 64'(last_period[ch]) << FRAC_BITS;
      if (unloaded[ch]) begin
        avg_period[ch] = target[TS_W+FRAC_BITS-1:0];
        unloaded[ch] = 1'b0;
      end else begin
        mixed = 64'(256 - int'(alpha)) * 64'(avg_period[ch]) + 64'(alpha) * target;
        avg_period[ch] = mixed[TS_W+FRAC_BITS+7:8];
      end
    end
    if (avg_period[ch] == '0) begin
      quot = '0;
    end else begin
      quot = (64'(FREQ_SCALE) << FRAC_BITS) / 64'(avg_period[ch]);
      if (quot > 64'(FREQ_LIMIT)) quot = 64'(FREQ_LIMIT);
    end
    r.ch = ch;
    r.period = last_period[ch];
    r.pulses = edges[ch];
    r.level = level[ch];
    r.avg = avg_period[ch];
    r.freq = quot[FREQ_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      alpha = ALPHA_RESET;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        capture_ts[c] = '0;
        last_period[c] = '0;
        edges[c] = '0;
        level[c] = 1'b0;
        avg_period[c] = '0;
        unloaded[c] = 1'b1;
      end
      expected_readings.delete();
      errors = 0;
    end else begin
      if (cfg_we) alpha = cfg_data;
      if (out_valid && !out_stall) begin
        got = '{result_channel, period_us, pulse_count, indicator_level,
                smoothed_period_q8, frequency_tenths_hz};
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: ch=%0d period=%0d pulses=%0d", got.ch, got.period,
                     got.pulses);
        end else begin
          want = expected_readings.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: ch=%0d period=%0d pulses=%0d ind=%0b avg=%0h freq=%0d",
                       want.ch, want.period, want.pulses, want.level, want.avg, want.freq);
              $display("         got: ch=%0d period=%0d pulses=%0d ind=%0b avg=%0h freq=%0d",
                       got.ch, got.period, got.pulses, got.level, got.avg, got.freq);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(advance_channel(op_t'(opcode), channel, timestamp_us));
    end
    pending = expected_readings.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, request stimulus, alpha settings and the final verdict
`timescale 1ns / 1ps

module tb_top;
  import pcef_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 160;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [ALPHA_W-1:0]            cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          opcode;
  logic                          channel;
  logic [TS_W-1:0]               timestamp_us;
  logic                          out_valid;
  logic                          out_stall;
  logic                          result_channel;
  logic [TS_W-1:0]               period_us;
  logic [TS_W-1:0]               pulse_count;
  logic                          indicator_level;
  logic [TS_W+FRAC_BITS_DEF-1:0] smoothed_period_q8;
  logic [FREQ_W-1:0]             frequency_tenths_hz;
  int                            errors;
  int                            pending;
  int                            cycles;
  logic                          calm;
  logic [TS_W-1:0]               now_ts[CHANNELS_DEF];

  period_counter_with_ema_frequency_unit i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .channel            (channel),
    .timestamp_us       (timestamp_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .result_channel     (result_channel),
    .period_us          (period_us),
    .pulse_count        (pulse_count),
    .indicator_level    (indicator_level),
    .smoothed_period_q8 (smoothed_period_q8),
    .frequency_tenths_hz(frequency_tenths_hz)
  );

  pcef_freq_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .channel            (channel),
    .timestamp_us       (timestamp_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .result_channel     (result_channel),
    .period_us          (period_us),
    .pulse_count        (pulse_count),
    .indicator_level    (indicator_level),
    .smoothed_period_q8 (smoothed_period_q8),
    .frequency_tenths_hz(frequency_tenths_hz),
    .errors             (errors),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap();
      out_stall = 1'b0;
      repeat (n == 0 ? 1 : n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL period_counter_with_ema_frequency_unit");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input op_t op, input logic ch, input logic [TS_W-1:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    channel = ch;
    timestamp_us = ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic edge_then_sample(input logic ch, input logic [TS_W-1:0] ts);
    send_request(OP_EDGE, ch, ts);
    send_request(OP_SAMPLE, ch, $urandom);
  endtask

  task automatic drain_and_set_alpha(input logic [ALPHA_W-1:0] a);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = a;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic        ch;
    int          r;
    logic [TS_W-1:0] step;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(3) == 0);
      ch = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 70) step = $urandom_range(50, 200000);
        else if (r < 80) step = $urandom_range(1, 50);
        else if (r < 90) step = $urandom;
        else if (r < 95) step = '0;
        else step = $urandom - now_ts[ch];
        now_ts[ch] = now_ts[ch] + step;
        send_request(OP_EDGE, ch, now_ts[ch]);
      end else begin
        send_request(OP_SAMPLE, ch, $urandom);
      end
    end
  endtask

  initial begin
    logic [ALPHA_W-1:0] alphas[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_EDGE;
    channel = 1'b0;
    timestamp_us = '0;
    calm = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: zero period before first load, extremes, wrap, first loads on both channels
    send_request(OP_SAMPLE, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_EDGE, 1'b0, 32'h0);
    send_request(OP_SAMPLE, 1'b0, 32'h0);
    edge_then_sample(1'b0, 32'hFFFF_FFFF);
    edge_then_sample(1'b0, 32'h0);
    edge_then_sample(1'b0, 32'h1);
    send_request(OP_SAMPLE, 1'b0, 32'h5555_5555);
    send_request(OP_SAMPLE, 1'b0, 32'hAAAA_AAAA);
    edge_then_sample(1'b1, 32'd1000);
    edge_then_sample(1'b1, 32'd1333);
    edge_then_sample(1'b1, 32'd500);
    edge_then_sample(1'b0, 32'h8000_0000);
    edge_then_sample(1'b1, 32'h7FFF_FFFF);
    send_request(OP_EDGE, 1'b1, 32'h7FFF_FFFF);
    send_request(OP_SAMPLE, 1'b1, 32'h0);
    now_ts[0] = 32'h8000_0000;
    now_ts[1] = 32'h7FFF_FFFF;

    random_phase(PHASE_ITEMS);
    alphas[0] = 8'd255;
    alphas[1] = 8'd1;
    alphas[2] = 8'd0;
    alphas[3] = 8'($urandom_range(2, 254));
    alphas[4] = 8'($urandom_range(2, 254));
    alphas[5] = ALPHA_RESET;
    foreach (alphas[k]) begin
      drain_and_set_alpha(alphas[k]);
      random_phase(PHASE_ITEMS);
    end

    in_valid = 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS period_counter_with_ema_frequency_unit");
    end else begin
      $display("FAIL period_counter_with_ema_frequency_unit");
    end
    $finish;
  end

endmodule
